@@ rtl/core/cie_pkg.sv @@
// Shared types and constants for the compressed instruction expander.
// Holds the bundle and issue-slot beat structs, size codes and expansion opcodes.
// No dependencies.
`default_nettype none

package cie_pkg;

    // Bundle form carried in the size code
    typedef enum logic [1:0] {
        SZ_ONE_SHORT = 2'd0,
        SZ_ONE_LONG  = 2'd1,
        SZ_TWO_SHORT = 2'd2,
        SZ_TWO_LONG  = 2'd3
    } t_size_code;

    // Template selector of a non-branch halfword, bits 12:9
    typedef enum logic [3:0] {
        COP_ALU_F0   = 4'd0,
        COP_ALU_F1   = 4'd1,
        COP_ALU_F4   = 4'd2,
        COP_ALU_F5   = 4'd3,
        COP_ALU_F11  = 4'd4,
        COP_ALU_F12  = 4'd5,
        COP_ALU_F14  = 4'd6,
        COP_HALU_F0  = 4'd7,
        COP_HALU_F1  = 4'd8,
        COP_IMM_DUP  = 4'd9,
        COP_IMM      = 4'd10,
        COP_LOAD_SP  = 4'd11,
        COP_STORE_SP = 4'd12,
        COP_LOAD     = 4'd13,
        COP_STORE    = 4'd14,
        COP_MOVE     = 4'd15
    } t_cop;

    // Fixed fields of the 32-bit forms
    localparam logic [31:0] OPC_BRANCH = 32'd12 << 26;
    localparam logic [31:0] OPC_ALU    = 32'd112 << 23;
    localparam logic [31:0] OPC_LOAD   = 32'd9 << 25;
    localparam logic [31:0] OPC_STORE  = 32'd11 << 25;
    localparam logic [31:0] SP_FIELD   = 32'd29 << 3;
    localparam logic [31:0] BASE_BITS  = 32'd4;

    // Input beat: one fetched bundle
    typedef struct packed {
        logic [31:0] first_word;
        logic [31:0] second_word;
        logic [1:0]  size_code;
    } t_in_item;

    // Output beat: two issue slots
    typedef struct packed {
        logic [31:0] slot0_instr;
        logic [31:0] slot1_instr;
    } t_out_item;

endpackage

`default_nettype wire

@@ rtl/core/cie_lane.sv @@
// One expansion lane: maps a 16-bit compressed form to its 32-bit form.
// Purely combinational. Depends on cie_pkg.
`default_nettype none

module cie_lane (
    input  wire logic [15:0] i_half,
    output logic [31:0]      o_instr
);

    // Build the three-register ALU form
    function automatic logic [31:0] alu_form(
        input logic [3:0] f,
        input logic [4:0] rd,
        input logic [4:0] rt,
        input logic [4:0] rs
    );
        alu_form = cie_pkg::BASE_BITS | cie_pkg::OPC_ALU | {10'd0, f, 18'd0}
                 | {14'd0, rd, 13'd0} | {19'd0, rt, 8'd0} | {24'd0, rs, 3'd0};
    endfunction

    logic [2:0]    fa;
    logic [2:0]    fb;
    logic [2:0]    fc;
    logic [3:0]    i4;
    logic [3:0]    lo4;
    logic [4:0]    hi5;
    logic [11:0]   imm;
    logic [31:0]   imm_f;
    cie_pkg::t_cop opc;

    // Slice the halfword fields
    assign fa    = i_half[2:0];
    assign fb    = i_half[5:3];
    assign fc    = i_half[8:6];
    assign i4    = i_half[8:5];
    assign lo4   = i_half[3:0];
    assign hi5   = i_half[8:4];
    assign imm   = {{7{i_half[4]}}, i_half[4:0]};
    assign imm_f = {7'd0, imm, 13'd0};
    assign opc   = cie_pkg::t_cop'(i_half[12:9]);

    // Select the template; bit 13 overrides with a branch
    always_comb begin
        if (i_half[13]) begin
            o_instr = cie_pkg::OPC_BRANCH | {6'd0, i_half[12], {13{i_half[8]}}, i_half[8:0],
                                             i_half[11:9]};
        end else begin
            case (opc)
                cie_pkg::COP_ALU_F0:   o_instr = alu_form(4'd0,  {2'b00, fc}, {2'b00, fb},
                                                          {2'b00, fa});
                cie_pkg::COP_ALU_F1:   o_instr = alu_form(4'd1,  {2'b00, fc}, {2'b00, fb},
                                                          {2'b00, fa});
                cie_pkg::COP_ALU_F4:   o_instr = alu_form(4'd4,  {2'b00, fc}, {2'b00, fb},
                                                          {2'b00, fa});
                cie_pkg::COP_ALU_F5:   o_instr = alu_form(4'd5,  {2'b00, fc}, {2'b00, fb},
                                                          {2'b00, fa});
                cie_pkg::COP_ALU_F11:  o_instr = alu_form(4'd11, {2'b00, fc}, {2'b00, fb},
                                                          {2'b00, fa});
                cie_pkg::COP_ALU_F12:  o_instr = alu_form(4'd12, {2'b00, fc}, {2'b00, fb},
                                                          {2'b00, fa});
                cie_pkg::COP_ALU_F14:  o_instr = alu_form(4'd14, {2'b00, fc}, {2'b00, fb},
                                                          {2'b00, fa});
                // high registers: add 8 to each register field
                cie_pkg::COP_HALU_F0:  o_instr = alu_form(4'd0,  {2'b01, fc}, {2'b01, fb},
                                                          {2'b01, fa});
                cie_pkg::COP_HALU_F1:  o_instr = alu_form(4'd1,  {2'b01, fc}, {2'b01, fb},
                                                          {2'b01, fa});
                cie_pkg::COP_IMM_DUP:  o_instr = cie_pkg::BASE_BITS | imm_f | {20'd0, i4, 8'd0}
                                               | {25'd0, i4, 3'd0};
                cie_pkg::COP_IMM:      o_instr = cie_pkg::BASE_BITS | imm_f | {20'd0, i4, 8'd0};
                cie_pkg::COP_LOAD_SP:  o_instr = cie_pkg::BASE_BITS | cie_pkg::OPC_LOAD | imm_f
                                               | {20'd0, i4, 8'd0} | cie_pkg::SP_FIELD;
                cie_pkg::COP_STORE_SP: o_instr = cie_pkg::BASE_BITS | cie_pkg::OPC_STORE | imm_f
                                               | {20'd0, i4, 8'd0} | cie_pkg::SP_FIELD;
                cie_pkg::COP_LOAD:     o_instr = cie_pkg::BASE_BITS | cie_pkg::OPC_LOAD
                                               | {19'd0, hi5, 8'd0} | {25'd0, lo4, 3'd0};
                cie_pkg::COP_STORE:    o_instr = cie_pkg::BASE_BITS | cie_pkg::OPC_STORE
                                               | {20'd0, i4, 8'd0} | {25'd0, lo4, 3'd0};
                cie_pkg::COP_MOVE:     o_instr = alu_form(4'd0, hi5, 5'd0, {1'b0, lo4});
                default:               o_instr = alu_form(4'd0, hi5, 5'd0, {1'b0, lo4});
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/cie_merge.sv @@
// Merge stage: picks slot contents from the lane results by size code and
// holds them in the output register. Depends on cie_pkg.
`default_nettype none

module cie_merge (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire cie_pkg::t_in_item i_in_data,
    input  wire logic [31:0]       i_hi_instr,
    input  wire logic [31:0]       i_lo_instr,
    input  wire logic [31:0]       i_nop_word,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output cie_pkg::t_out_item     o_out_data
);

    logic               r_valid;
    logic               n_valid;
    cie_pkg::t_out_item r_data;
    cie_pkg::t_out_item n_data;
    logic               in_fire;

    // Take a new beat whenever the output register is empty or draining
    assign o_in_ready = !r_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    // Route lanes and passthrough words into the slots
    always_comb begin
        case (cie_pkg::t_size_code'(i_in_data.size_code))
            cie_pkg::SZ_ONE_SHORT: begin
                n_data.slot0_instr = i_hi_instr;
                n_data.slot1_instr = i_nop_word;
            end
            cie_pkg::SZ_ONE_LONG: begin
                n_data.slot0_instr = i_in_data.first_word;
                n_data.slot1_instr = i_nop_word;
            end
            cie_pkg::SZ_TWO_SHORT: begin
                n_data.slot0_instr = i_hi_instr;
                n_data.slot1_instr = i_lo_instr;
            end
            cie_pkg::SZ_TWO_LONG: begin
                n_data.slot0_instr = i_in_data.first_word;
                n_data.slot1_instr = i_in_data.second_word;
            end
            default: begin
                n_data.slot0_instr = i_in_data.first_word;
                n_data.slot1_instr = i_in_data.second_word;
            end
        endcase
    end

    // Advance valid: set on accept, drop once taken
    always_comb begin
        if (in_fire) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Load the payload only on accept
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_data <= n_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    // An empty output register never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

    // An accepted bundle always shows up on the next cycle
    a_accept_to_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_valid)
        else $error("accepted bundle not presented");

    // Two short halves land in the slots from the matching lanes
    a_two_short_route: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in_data.size_code == cie_pkg::SZ_TWO_SHORT
        |=> r_data.slot0_instr == $past(i_hi_instr) && r_data.slot1_instr == $past(i_lo_instr))
        else $error("two short halves misrouted");

endmodule

`default_nettype wire

@@ rtl/core/compressed_instruction_expander_core.sv @@
// Top level of the compressed instruction expander: no-op register, two
// expansion lanes and the merge stage. Depends on cie_pkg, cie_lane, cie_merge.
`default_nettype none

// Takes one fetched bundle per clock and delivers two 32-bit issue slots in the
// next cycle through a single output register; a new bundle is accepted in
// the same cycle the previous result is taken, so a full stream runs at one
// bundle per cycle. Two expansion lanes decode the upper and lower halfwords
// side by side and the merge stage picks per size code. An unused slot carries
// the no-op word written on the configuration channel (reset value 0); the
// configuration channel is always ready and should only be written when idle.

module compressed_instruction_expander_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire cie_pkg::t_in_item i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output cie_pkg::t_out_item     o_out_data,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [31:0]       i_cfg_nop_word
);

    logic [31:0] r_nop_word;
    logic [31:0] hi_instr;
    logic [31:0] lo_instr;
    logic        in_fire;

    // Hold the no-op word
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nop_word <= 32'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_nop_word <= i_cfg_nop_word;
        end
    end

    // Expand both halfwords of the first word in parallel
    cie_lane u_lane_hi (
        .i_half  (i_in_data.first_word[31:16]),
        .o_instr (hi_instr)
    );

    cie_lane u_lane_lo (
        .i_half  (i_in_data.first_word[15:0]),
        .o_instr (lo_instr)
    );

    // Select slots and register the result
    cie_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_hi_instr  (hi_instr),
        .i_lo_instr  (lo_instr),
        .i_nop_word  (r_nop_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    assign in_fire = i_in_valid && o_in_ready;

    // One long instruction passes through with the no-op in slot one
    a_one_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in_data.size_code == cie_pkg::SZ_ONE_LONG
        |=> o_out_data.slot0_instr == $past(i_in_data.first_word)
            && o_out_data.slot1_instr == $past(r_nop_word))
        else $error("one long bundle mishandled");

    // Two long instructions pass through unchanged
    a_two_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in_data.size_code == cie_pkg::SZ_TWO_LONG
        |=> o_out_data.slot0_instr == $past(i_in_data.first_word)
            && o_out_data.slot1_instr == $past(i_in_data.second_word))
        else $error("two long bundle mishandled");

    // One short instruction gets the no-op in slot one
    a_one_short_nop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in_data.size_code == cie_pkg::SZ_ONE_SHORT
        |=> o_out_data.slot1_instr == $past(r_nop_word))
        else $error("one short bundle missing no-op");

endmodule

`default_nettype wire

@@ sim/cie_issue_monitor.sv @@
// Watches the bundle, issue-slot and no-op channels of the expander core,
// predicts both issue slots per accepted bundle and compares them in order.
// Depends on cie_pkg for the beat structs, size codes and template selectors.
`timescale 1ns / 1ps

module cie_issue_monitor (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  cie_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  cie_pkg::t_out_item i_out_data,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [31:0]        i_cfg_nop_word,
    output int                 o_fail_count,
    output int                 o_pending
);
    import cie_pkg::*;

    // Fixed fields of the 32-bit forms
    localparam logic [31:0] BR_MAJOR  = 32'd12 << 26;
    localparam logic [31:0] ALU_MAJOR = 32'd112 << 23;
    localparam logic [31:0] LD_MAJOR  = 32'd9 << 25;
    localparam logic [31:0] ST_MAJOR  = 32'd11 << 25;
    localparam logic [31:0] SP_RS     = 32'd29 << 3;
    localparam logic [31:0] FORM_BITS = 32'd4;

    t_out_item   slot_queue[$];
    logic [31:0] nop_word;
    int          fails;

    function automatic logic [31:0] alu_word(logic [3:0] f, logic [4:0] rd,
                                             logic [4:0] rt, logic [4:0] rs);
        return FORM_BITS | ALU_MAJOR | (32'(f) << 18) | (32'(rd) << 13)
             | (32'(rt) << 8) | (32'(rs) << 3);
    endfunction

    function automatic logic [31:0] expand_halfword(logic [15:0] h);
        logic [21:0] offset;
        logic [11:0] imm;
        logic [4:0]  ra, rb, rc, hi5;
        logic [3:0]  i4, lo4;
        logic [31:0] imm_field;
        t_cop        op;
        offset    = {{13{h[8]}}, h[8:0]};
        imm       = {{7{h[4]}}, h[4:0]};
        imm_field = 32'(imm) << 13;
        ra        = 5'(h[2:0]);
        rb        = 5'(h[5:3]);
        rc        = 5'(h[8:6]);
        i4        = h[8:5];
        lo4       = h[3:0];
        hi5       = h[8:4];
        op        = t_cop'(h[12:9]);
        // bit 13 overrides the template selector
        if (h[13]) begin
            return BR_MAJOR | (32'(h[12]) << 25) | (32'(offset) << 3) | 32'(h[11:9]);
        end
        case (op)
            COP_ALU_F0:   return alu_word(4'd0, rc, rb, ra);
            COP_ALU_F1:   return alu_word(4'd1, rc, rb, ra);
            COP_ALU_F4:   return alu_word(4'd4, rc, rb, ra);
            COP_ALU_F5:   return alu_word(4'd5, rc, rb, ra);
            COP_ALU_F11:  return alu_word(4'd11, rc, rb, ra);
            COP_ALU_F12:  return alu_word(4'd12, rc, rb, ra);
            COP_ALU_F14:  return alu_word(4'd14, rc, rb, ra);
            // high-register forms reach r8..r15
            COP_HALU_F0:  return alu_word(4'd0, rc + 5'd8, rb + 5'd8, ra + 5'd8);
            COP_HALU_F1:  return alu_word(4'd1, rc + 5'd8, rb + 5'd8, ra + 5'd8);
            COP_IMM_DUP:  return FORM_BITS | imm_field | (32'(i4) << 8) | (32'(i4) << 3);
            COP_IMM:      return FORM_BITS | imm_field | (32'(i4) << 8);
            COP_LOAD_SP:  return FORM_BITS | LD_MAJOR | imm_field | (32'(i4) << 8) | SP_RS;
            COP_STORE_SP: return FORM_BITS | ST_MAJOR | imm_field | (32'(i4) << 8) | SP_RS;
            COP_LOAD:     return FORM_BITS | LD_MAJOR | (32'(hi5) << 8) | (32'(lo4) << 3);
            COP_STORE:    return FORM_BITS | ST_MAJOR | (32'(i4) << 8) | (32'(lo4) << 3);
            default:      return alu_word(4'd0, hi5, 5'd0, 5'(lo4));
        endcase
    endfunction

    function automatic t_out_item predict_slots(t_in_item b, logic [31:0] nop);
        t_out_item s;
        case (t_size_code'(b.size_code))
            SZ_ONE_SHORT: begin
                s.slot0_instr = expand_halfword(b.first_word[31:16]);
                s.slot1_instr = nop;
            end
            SZ_ONE_LONG: begin
                s.slot0_instr = b.first_word;
                s.slot1_instr = nop;
            end
            SZ_TWO_SHORT: begin
                s.slot0_instr = expand_halfword(b.first_word[31:16]);
                s.slot1_instr = expand_halfword(b.first_word[15:0]);
            end
            default: begin
                s.slot0_instr = b.first_word;
                s.slot1_instr = b.second_word;
            end
        endcase
        return s;
    endfunction

    // Track the no-op word, queue predictions, compare issue beats in order
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            nop_word = '0;
            slot_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                nop_word = i_cfg_nop_word;
            end
            if (i_in_valid && i_in_ready) begin
                slot_queue.insert(slot_queue.size(), predict_slots(i_in_data, nop_word));
            end
            if (i_out_valid && i_out_ready) begin
                if (slot_queue.size() == 0) begin
                    $display("%0t: issue beat %016h arrived with nothing expected",
                             $time, i_out_data);
                    fails++;
                end else begin
                    want = slot_queue.pop_front();
                    if (i_out_data.slot0_instr !== want.slot0_instr) begin
                        $display("%0t: slot0 expected %08h actual %08h",
                                 $time, want.slot0_instr, i_out_data.slot0_instr);
                        fails++;
                    end
                    if (i_out_data.slot1_instr !== want.slot1_instr) begin
                        $display("%0t: slot1 expected %08h actual %08h",
                                 $time, want.slot1_instr, i_out_data.slot1_instr);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= slot_queue.size();
    end

endmodule

@@ sim/compressed_instruction_expander_core_tb.sv @@
// Stimulus and verdict for the compressed instruction expander core.
// Depends on cie_pkg, the core RTL and cie_issue_monitor for prediction and compare.
`timescale 1ns / 1ps

module compressed_instruction_expander_core_tb;
    import cie_pkg::*;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    t_in_item    i_in_data      = '0;
    logic        i_out_ready    = 1'b0;
    logic        i_cfg_valid    = 1'b0;
    logic [31:0] i_cfg_nop_word = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_cfg_ready;
    t_out_item   o_out_data;
    int          fail_count;
    int          pending;
    int          idle_pct       = 0;
    int          stall_pct      = 0;

    compressed_instruction_expander_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_data      (i_in_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_data     (o_out_data),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_nop_word (i_cfg_nop_word)
    );

    cie_issue_monitor monitor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_in_data      (i_in_data),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_out_data     (o_out_data),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_nop_word (i_cfg_nop_word),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always #5 i_clk = ~i_clk;

    // Stall the issue side at the current phase rate
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic t_in_item make_bundle(logic [31:0] first, logic [31:0] second,
                                             t_size_code sz);
        t_in_item b;
        b.first_word  = first;
        b.second_word = second;
        b.size_code   = sz;
        return b;
    endfunction

    // Hold valid until the beat is taken; valid stays up for a back-to-back beat
    task automatic send_bundle(t_in_item b);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Drop valid and let every predicted issue beat drain
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_nop_word(logic [31:0] value);
        i_cfg_valid    <= 1'b1;
        i_cfg_nop_word <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int count, int in_idle, int out_stall);
        t_size_code sz;
        idle_pct  = in_idle;
        stall_pct = out_stall;
        repeat (count) begin
            // lean toward two-short bundles to exercise both expansion lanes
            sz = ($urandom_range(3) == 0) ? t_size_code'($urandom_range(3)) : SZ_TWO_SHORT;
            send_bundle(make_bundle($urandom, $urandom, sz));
        end
        drain();
    endtask

    initial begin
        t_cop op;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: size-code extremes against the reset no-op word
        send_bundle(make_bundle(32'h0000_0000, 32'hFFFF_FFFF, SZ_ONE_SHORT));
        send_bundle(make_bundle(32'hFFFF_FFFF, 32'h0000_0000, SZ_ONE_SHORT));
        send_bundle(make_bundle(32'hFFFF_FFFF, 32'h5A5A_A5A5, SZ_ONE_LONG));
        send_bundle(make_bundle(32'h0000_0000, 32'hFFFF_FFFF, SZ_ONE_LONG));
        send_bundle(make_bundle(32'hFFFF_FFFF, 32'h0000_0000, SZ_TWO_LONG));
        send_bundle(make_bundle(32'h0000_0000, 32'hFFFF_FFFF, SZ_TWO_LONG));
        send_bundle(make_bundle(32'hFFFF_FFFF, 32'hFFFF_FFFF, SZ_TWO_SHORT));

        // Every template, two per bundle, with random ignored top bits
        op = COP_ALU_F0;
        repeat (8) begin
            send_bundle(make_bundle(
                {2'($urandom_range(3)), 1'b0, op, 9'($urandom),
                 2'($urandom_range(3)), 1'b0, op.next(), 9'($urandom)},
                $urandom, SZ_TWO_SHORT));
            op = op.next(2);
        end

        // Branch offset sign, immediate sign, unused top bits set
        send_bundle(make_bundle({2'b00, 1'b1, 4'hF, 9'h100, 2'b11, 1'b1, 4'h0, 9'h0FF},
                                32'h0, SZ_TWO_SHORT));
        send_bundle(make_bundle({2'b11, 1'b0, COP_LOAD_SP, 4'h0, 5'h10,
                                 2'b10, 1'b0, COP_STORE_SP, 4'hF, 5'h0F},
                                32'h0, SZ_TWO_SHORT));
        send_bundle(make_bundle({2'b01, 1'b0, COP_IMM_DUP, 4'hA, 5'h1F,
                                 2'b11, 1'b0, COP_IMM, 4'h5, 5'h00},
                                32'hFFFF_FFFF, SZ_TWO_SHORT));
        drain();

        // Random phases, each under its own no-op word
        write_nop_word(32'hFFFF_FFFF);
        run_random(160, 0, 0);
        write_nop_word(32'h0000_0000);
        run_random(160, 88, 0);
        write_nop_word($urandom);
        run_random(160, 0, 88);
        write_nop_word(32'h8000_0001);
        run_random(170, 18, 18);

        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
